>>> rtl/sba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_pkg: shared types and codes for the swapping block allocator
// Operation and status codes, controller states, command and status structs.
// ---------------------------------------------------------------------------
package sba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_SWAPIN = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OK_SWAP  = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_BAD_PROC = 3'd3,
    ST_TBL_FULL = 3'd4,
    ST_BAD_SIZE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIT1,
    S_VSCAN,
    S_DFIT,
    S_EVICT,
    S_FIT2,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture request
    logic fit_mem;    // run first-fit on memory map
    logic vscan_clr;  // start victim scan
    logic vscan_step; // test one process entry
    logic fit_disk;   // first fit for victim on disk
    logic evict;      // move victim to disk
    logic commit;     // apply operation
    logic fail;       // mark no space
  } sba_cmd_t;

  typedef struct packed {
    logic    early;      // decode finished with result (error/free/query/resident swap-in)
    logic    fit_found;
    logic    vscan_hit;
    logic    vscan_end;
    logic    disk_found;
  } sba_sts_t;

endpackage

>>> rtl/sba_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_req_if / sba_rsp_if: valid/ready channels
// Request and response channels of the allocator.
// ---------------------------------------------------------------------------
interface sba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] request_bytes;
  logic [5:0]  process_id;
  modport source (output valid, operation, request_bytes, process_id, input ready);
  modport sink (input valid, operation, request_bytes, process_id, output ready);
endinterface

interface sba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] result_pid;
  logic [5:0] start_block;
  logic [5:0] victim_pid;
  logic       in_memory;
  modport source (output valid, status, result_pid, start_block, victim_pid, in_memory,
                  input ready);
  modport sink (input valid, status, result_pid, start_block, victim_pid, in_memory,
                output ready);
endinterface

>>> rtl/swapping_block_allocator_core.sv
`timescale 1ns / 1ps
// Sequence: errors, free, query and resident swap-in respond from decode; allocate
//   and swap-in run first fit, then on a miss a victim scan of the process table,
//   one entry per cycle, then disk fit, eviction and a second fit before commit.
// Throughput: one request at a time; next transfer accepted after the response.
// Reset: synchronous; maps, process table valid bits and pid counter cleared.
// ---------------------------------------------------------------------------
// swapping_block_allocator_core: first-fit block allocator with swapping
// Controller sequences each request; datapath holds maps and process table.
// ---------------------------------------------------------------------------
module swapping_block_allocator_core
  import sba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 4,
  parameter int BLOCK_BYTES = 16,
  parameter int MAX_PROCS   = 64
) (
  input logic clk,
  input logic rst,
  sba_req_if.sink   req,
  sba_rsp_if.source rsp
);

  sba_cmd_t cmd;
  sba_sts_t sts;

  // sequencer: one request in flight, response held until its transfer
  sba_ctrl u_ctrl (
    .clk, .rst,
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd, .sts
  );

  // maps, table and result registers
  sba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_PROCS  (MAX_PROCS)
  ) u_dp (
    .clk, .rst, .cmd, .sts,
    .operation     (req.operation),
    .request_bytes (req.request_bytes),
    .process_id    (req.process_id),
    .status        (rsp.status),
    .result_pid    (rsp.result_pid),
    .start_block   (rsp.start_block),
    .victim_pid    (rsp.victim_pid),
    .in_memory     (rsp.in_memory)
  );

endmodule

>>> rtl/sba_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_ctrl: request sequencer
// Steps each request through fit, victim scan, eviction and commit.
// ---------------------------------------------------------------------------
module sba_ctrl
  import sba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sba_cmd_t cmd,
  input  sba_sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: if (sts.early) state_next = S_DONE;
                else state_next = S_FIT1;
      S_FIT1:   if (sts.fit_found) state_next = S_COMMIT;
                else state_next = S_VSCAN;
      S_VSCAN:  if (sts.vscan_hit) state_next = S_DFIT;
                else if (sts.vscan_end) state_next = S_COMMIT;
      S_DFIT:   if (sts.disk_found) state_next = S_EVICT;
                else state_next = S_COMMIT;
      S_EVICT:  state_next = S_FIT2;
      S_FIT2:   state_next = S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_DONE:   if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_DONE);
    case (state)
      S_IDLE:   cmd.load = in_valid;
      S_FIT1:   begin
        cmd.fit_mem = 1'b1;
        cmd.vscan_clr = 1'b1;
      end
      S_VSCAN:  begin
        cmd.vscan_step = 1'b1;
        cmd.fail = sts.vscan_end && !sts.vscan_hit;
      end
      S_DFIT:   begin
        cmd.fit_disk = 1'b1;
        cmd.fail = !sts.disk_found;
      end
      S_EVICT:  cmd.evict = 1'b1;
      S_FIT2:   cmd.fit_mem = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      default:  ;
    endcase
  end

endmodule

>>> rtl/sba_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_dp: allocator datapath
// Block maps, process table, first-fit unit, victim scan and result registers.
// ---------------------------------------------------------------------------
module sba_dp
  import sba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 4,
  parameter int BLOCK_BYTES = 16,
  parameter int MAX_PROCS   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  sba_cmd_t    cmd,
  output sba_sts_t    sts,
  input  logic [1:0]  operation,
  input  logic [15:0] request_bytes,
  input  logic [5:0]  process_id,
  output logic [2:0]  status,
  output logic [5:0]  result_pid,
  output logic [5:0]  start_block,
  output logic [5:0]  victim_pid,
  output logic        in_memory
);

  localparam int BW = $clog2(NUM_BLOCKS + 1);
  localparam int SW = 16 - $clog2(BLOCK_BYTES) + 1;
  localparam int TW = BW + 6;

  logic [NUM_BLOCKS-1:0] mem_map, disk_map;
  logic [MAX_PROCS-1:0]  pvalid, presid;
  logic [6:0]            next_pid;

  // process table, {size, start} per pid; two registered read ports
  logic [TW-1:0] ptab [MAX_PROCS];
  logic [TW-1:0] pid_ent, scan_ent;
  logic [BW-1:0] pid_size, scan_size;
  logic [5:0]    pid_start, scan_start;
  logic          tab_we;
  logic [5:0]    tab_wa;
  logic [TW-1:0] tab_wd;

  // latched request
  op_t        op;
  logic [SW-1:0] blk_req;
  logic [5:0] pid;
  logic [BW-1:0] need;
  logic [5:0] fit_pos;
  logic       fit_ok;
  logic [5:0] scan, scan_next, victim;
  logic       swapped, failed;
  logic       fin_free, dec_q;

  // block count: ceil(bytes / BLOCK_BYTES), constant divide
  logic [16:0] bytes_up;
  logic [SW-1:0] blocks;
  assign bytes_up = {1'b0, request_bytes} + 17'(BLOCK_BYTES - 1);
  assign blocks   = SW'(bytes_up / BLOCK_BYTES);

  // first fit over a map (narrow map, independent start positions)
  function automatic logic [6:0] first_fit(input logic [NUM_BLOCKS-1:0] map,
                                           input logic [BW-1:0] n);
    logic [6:0] r;
    logic ok;
    r = 7'h40;
    for (int s = NUM_BLOCKS - 1; s >= 0; s--) begin
      ok = (n != '0) && (32'(s) + 32'(n) <= NUM_BLOCKS);
      for (int k = 0; k < NUM_BLOCKS; k++)
        if (k < int'(n) && s + k < NUM_BLOCKS && map[s + k]) ok = 1'b0;
      if (ok) r = 7'(s);
    end
    return r;
  endfunction

  function automatic logic [NUM_BLOCKS-1:0] run_mask(input logic [5:0] st,
                                                     input logic [BW-1:0] n);
    logic [NUM_BLOCKS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_BLOCKS; i++)
      m[i] = (i >= int'(st)) && (i < int'(st) + int'(n));
    return m;
  endfunction

  assign {pid_size, pid_start}   = pid_ent;
  assign {scan_size, scan_start} = scan_ent;

  logic [6:0] mfit, dfit;
  assign mfit = first_fit(mem_map, need);
  assign dfit = first_fit(disk_map, scan_size);

  logic pid_bad;
  assign pid_bad = (pid == '0) || (32'(pid) >= MAX_PROCS) || !pvalid[pid];

  logic early;
  always_comb begin
    if (op == OP_ALLOC)
      early = (blk_req == '0) || (32'(blk_req) > NUM_BLOCKS) ||
              (32'(next_pid) + 1 >= MAX_PROCS);
    else
      early = pid_bad || op != OP_SWAPIN || presid[pid];
  end

  assign sts.early      = early;
  assign sts.fit_found  = !mfit[6];
  assign sts.vscan_hit  = pvalid[scan] && presid[scan] && scan_size >= need;
  assign sts.vscan_end  = (32'(scan) >= MAX_PROCS - 1);
  assign sts.disk_found = !dfit[6];

  // scan pointer; its next value also addresses the scan read port
  always_comb begin
    scan_next = scan;
    if (cmd.vscan_clr) scan_next = 6'd1;
    else if (cmd.vscan_step && !sts.vscan_hit && !sts.vscan_end) scan_next = scan + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) scan <= 6'd1;
    else     scan <= scan_next;
  end

  // one table write a cycle: victim relocation or commit
  always_comb begin
    tab_we = 1'b0;
    tab_wa = scan;
    tab_wd = {scan_size, fit_pos};
    if (cmd.evict) begin
      tab_we = 1'b1;
    end else if (cmd.commit && !failed && fit_ok) begin
      tab_we = 1'b1;
      tab_wa = (op == OP_ALLOC) ? next_pid[5:0] + 6'd1 : pid;
      tab_wd = {need, fit_pos};
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) ptab[tab_wa] <= tab_wd;
    if (cmd.load) pid_ent <= ptab[process_id];
    scan_ent <= ptab[scan_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_map  <= '0;
      disk_map <= '0;
      pvalid   <= '0;
      presid   <= '0;
      next_pid <= '0;
    end else begin
      if (cmd.load) begin
        op      <= op_t'(operation);
        blk_req <= blocks;
        pid     <= process_id;
        swapped <= 1'b0;
        failed  <= 1'b0;
        victim  <= '0;
      end
      if (cmd.fit_mem) begin
        fit_pos <= mfit[5:0];
        fit_ok  <= !mfit[6];
      end
      if (cmd.fail) failed <= 1'b1;
      if (cmd.fit_disk && sts.disk_found) fit_pos <= dfit[5:0];
      if (cmd.evict) begin
        disk_map      <= disk_map | run_mask(fit_pos, scan_size);
        mem_map       <= mem_map & ~run_mask(scan_start, scan_size);
        presid[scan]  <= 1'b0;
        victim        <= scan;
        swapped       <= 1'b1;
      end
      if (cmd.commit) begin
        if (failed || !fit_ok) begin
          failed <= 1'b1;
        end else if (op == OP_ALLOC) begin
          next_pid                 <= next_pid + 7'd1;
          mem_map                  <= mem_map | run_mask(fit_pos, need);
          presid[next_pid[5:0] + 6'd1] <= 1'b1;
          pvalid[next_pid[5:0] + 6'd1] <= 1'b1;
        end else begin
          disk_map    <= disk_map & ~run_mask(pid_start, pid_size);
          mem_map     <= mem_map | run_mask(fit_pos, need);
          presid[pid] <= 1'b1;
        end
      end
      // free happens at decode
      if (cmd.load == 1'b0 && op == OP_FREE && early && !pid_bad && fin_free) begin
        if (presid[pid]) mem_map <= mem_map & ~run_mask(pid_start, pid_size);
        else disk_map <= disk_map & ~run_mask(pid_start, pid_size);
        pvalid[pid] <= 1'b0;
        presid[pid] <= 1'b0;
      end
    end
  end

  // free is applied once, on the decode cycle
  always_ff @(posedge clk) begin
    if (rst) dec_q <= 1'b0;
    else     dec_q <= cmd.load;
  end
  assign fin_free = dec_q;

  always_ff @(posedge clk) begin
    if (cmd.load) need <= '0;
    else if (dec_q) need <= (op == OP_ALLOC) ? BW'(blk_req) : pid_size;
  end

  // result, formed in decode (early) or commit
  always_ff @(posedge clk) begin
    if (dec_q && early) begin
      victim_pid <= '0;
      if (op == OP_ALLOC) begin
        status      <= (blk_req == '0 || 32'(blk_req) > NUM_BLOCKS) ? ST_BAD_SIZE
                                                                      : ST_TBL_FULL;
        result_pid  <= '0;
        start_block <= '0;
        in_memory   <= 1'b0;
      end else begin
        status      <= pid_bad ? ST_BAD_PROC : ST_OK;
        result_pid  <= pid;
        in_memory   <= !pid_bad && op != OP_FREE && presid[pid];
        start_block <= (!pid_bad && op != OP_FREE && presid[pid]) ? pid_start : '0;
      end
    end
    if (cmd.commit) begin
      if (failed || !fit_ok) begin
        status      <= ST_NO_SPACE;
        result_pid  <= (op == OP_ALLOC) ? 6'd0 : pid;
        start_block <= '0;
        victim_pid  <= '0;
        in_memory   <= 1'b0;
      end else begin
        status      <= swapped ? ST_OK_SWAP : ST_OK;
        result_pid  <= (op == OP_ALLOC) ? next_pid[5:0] + 6'd1 : pid;
        start_block <= fit_pos;
        victim_pid  <= victim;
        in_memory   <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/sba_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_checker: port-level checks
// Response ordering and field consistency seen at the ports.
// ---------------------------------------------------------------------------
module sba_checker
  import sba_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] status,
  input logic [5:0] victim_pid,
  input logic       in_memory
);

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid)) else $error("accept while response pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("response dropped");

  a_victim: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK_SWAP |-> victim_pid == 6'd0)
    else $error("victim without swap");

  a_fail_mem: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status >= ST_NO_SPACE |-> !in_memory)
    else $error("failure reports residence");

endmodule

bind swapping_block_allocator_core sba_checker u_chk (
  .clk, .rst,
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .victim_pid (rsp.victim_pid),
  .in_memory  (rsp.in_memory)
);

>>> verif/tb_swapping_block_allocator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_swapping_block_allocator_core: self-checking bench for the allocator
// Directed and random request streams through the valid/ready channels. An
// in-bench model of the maps and process table predicts each response, and
// a monitor compares responses in order, field by field.
// ---------------------------------------------------------------------------
module tb_swapping_block_allocator_core;
  import sba_pkg::*;

  localparam int NBLK  = 4;
  localparam int BBYTE = 16;
  localparam int NPROC = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] pid;
    logic [5:0] start;
    logic [5:0] victim;
    logic       inmem;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sba_req_if req ();
  sba_rsp_if rsp ();

  swapping_block_allocator_core #(
    .NUM_BLOCKS(NBLK), .BLOCK_BYTES(BBYTE), .MAX_PROCS(NPROC)
  ) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the allocator state
  logic       mem_used [NBLK];
  logic       disk_used [NBLK];
  logic [6:0] p_size [NPROC];
  logic [5:0] p_start [NPROC];
  logic       p_res [NPROC];
  logic       p_live [NPROC];
  logic [6:0] last_pid;

  alloc_rsp_t pending_rsps[$];
  int mismatches = 0;
  int cycles = 0;

  // Lowest start of a free run of n blocks, -1 if none
  function automatic int run_search(input bit on_disk, input int n);
    bit ok;
    if (n == 0 || n > NBLK) return -1;
    for (int s = 0; s + n <= NBLK; s++) begin
      ok = 1'b1;
      for (int k = 0; k < n; k++)
        if (on_disk ? disk_used[s+k] : mem_used[s+k]) ok = 1'b0;
      if (ok) return s;
    end
    return -1;
  endfunction

  function automatic void set_run(input bit on_disk, input int s, input int n, input logic v);
    for (int k = 0; k < n && s + k < NBLK; k++)
      if (on_disk) disk_used[s+k] = v; else mem_used[s+k] = v;
  endfunction

  // Push the lowest resident process of at least need blocks out to disk
  function automatic bit push_to_disk(input int need, output int vic);
    int p, d;
    vic = 0;
    for (p = 1; p < NPROC; p++)
      if (p_live[p] && p_res[p] && p_size[p] >= need) break;
    if (p >= NPROC) return 1'b0;
    d = run_search(1'b1, p_size[p]);
    if (d < 0) return 1'b0;
    set_run(1'b1, d, p_size[p], 1'b1);
    set_run(1'b0, p_start[p], p_size[p], 1'b0);
    p_start[p] = 6'(d);
    p_res[p] = 1'b0;
    vic = p;
    return 1'b1;
  endfunction

  function automatic alloc_rsp_t predict_alloc(input op_t op, input int bytes, input int pid);
    alloc_rsp_t r;
    int blocks, m, vic, n;
    r = '0;
    if (op == OP_ALLOC) begin
      blocks = (bytes + BBYTE - 1) / BBYTE;
      if (blocks == 0 || blocks > NBLK) r.status = ST_BAD_SIZE;
      else if (last_pid + 1 >= NPROC) r.status = ST_TBL_FULL;
      else begin
        r.status = ST_OK;
        m = run_search(1'b0, blocks);
        if (m < 0 && push_to_disk(blocks, vic)) begin
          r.status = ST_OK_SWAP; r.victim = 6'(vic);
          m = run_search(1'b0, blocks);
        end
        if (m < 0) begin
          r.status = ST_NO_SPACE; r.victim = 6'd0;
        end else begin
          last_pid = last_pid + 7'd1;
          r.pid = last_pid[5:0];
          set_run(1'b0, m, blocks, 1'b1);
          p_size[last_pid] = 7'(blocks); p_start[last_pid] = 6'(m);
          p_res[last_pid] = 1'b1; p_live[last_pid] = 1'b1;
          r.start = 6'(m); r.inmem = 1'b1;
        end
      end
    end else begin
      r.pid = 6'(pid);
      if (pid == 0 || !p_live[pid]) r.status = ST_BAD_PROC;
      else if (op == OP_FREE) begin
        r.status = ST_OK;
        set_run(!p_res[pid], p_start[pid], p_size[pid], 1'b0);
        p_live[pid] = 1'b0; p_res[pid] = 1'b0;
      end else if (op == OP_QUERY || p_res[pid]) begin
        r.status = ST_OK;
        r.inmem = p_res[pid];
        r.start = p_res[pid] ? p_start[pid] : 6'd0;
      end else begin
        // Swap in: the victim's disk run is sought while this one still holds its own
        r.status = ST_OK;
        n = p_size[pid];
        m = run_search(1'b0, n);
        if (m < 0 && push_to_disk(n, vic)) begin
          r.status = ST_OK_SWAP; r.victim = 6'(vic);
          m = run_search(1'b0, n);
        end
        if (m < 0) begin
          r.status = ST_NO_SPACE; r.victim = 6'd0;
        end else begin
          set_run(1'b1, p_start[pid], n, 1'b0);
          set_run(1'b0, m, n, 1'b1);
          p_start[pid] = 6'(m); p_res[pid] = 1'b1;
          r.start = 6'(m); r.inmem = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Drive one request and wait for its transfer; valid drops only across an idle gap
  task automatic send_request(input op_t op, input int bytes, input int pid);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.request_bytes <= bytes[15:0];
    req.process_id <= pid[5:0];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsps.push_back(predict_alloc(op, bytes, pid));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk);
    repeat (NPROC + 20) @(negedge clk);
  endtask

  // Response checker; ready stalls drawn per response
  initial begin
    int stall;
    alloc_rsp_t got, want;
    rsp.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 6);
      @(negedge clk);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp.valid && rsp.ready)) @(posedge clk);
      got = '{rsp.status, rsp.result_pid, rsp.start_block, rsp.victim_pid, rsp.in_memory};
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
      end else begin
        want = pending_rsps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d pid %0d/%0d start %0d/%0d victim %0d/%0d mem %0d/%0d",
                     want.status, got.status, want.pid, got.pid, want.start, got.start,
                     want.victim, got.victim, want.inmem, got.inmem);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Size and pid extremes, every operation, bad pids
  task automatic test_directed();
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 65535, 63);
    send_request(OP_ALLOC, 65, 0);
    send_request(OP_QUERY, 0, 0);
    send_request(OP_FREE, 0, 63);
    send_request(OP_SWAPIN, 0, 5);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 16, 0);
    send_request(OP_ALLOC, 33, 0);
    send_request(OP_ALLOC, 64, 0);      // no contiguous fit and no victim large enough: no space
    send_request(OP_QUERY, 0, 3);
    send_request(OP_SWAPIN, 0, 1);      // resident swap-in
    send_request(OP_SWAPIN, 0, 3);      // pid 3 was never allocated: bad pid
    send_request(OP_ALLOC, 64, 0);      // no resident victim of four blocks: no space
    send_request(OP_FREE, 0, 4);        // free of a pid that was never allocated
    send_request(OP_FREE, 0, 4);
    send_request(OP_FREE, 0, 3);
    send_request(OP_QUERY, 0, 1);
    send_request(OP_ALLOC, 48, 0);
  endtask

  task automatic test_random(input int count);
    int op, pid, bytes;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(0, 3);
      pid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
            : $urandom_range(1, (last_pid == 0) ? 1 : last_pid);
      bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 70);
      send_request(op_t'(op), bytes, pid);
    end
  endtask

  // Table exhaustion: empty both maps, then allocate and free until pids run out
  task automatic test_table_full();
    for (int p = 1; p < NPROC; p++)
      if (p_live[p]) send_request(OP_FREE, 0, p);
    while (last_pid < NPROC - 1) begin
      send_request(OP_ALLOC, 16, 0);
      send_request(OP_FREE, 0, last_pid);
    end
    send_request(OP_ALLOC, 16, 0);
    send_request(OP_FREE, 0, 63);
    test_random(300);
  endtask

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      mem_used[i] = 0; disk_used[i] = 0;
    end
    for (int i = 0; i < NPROC; i++) begin
      p_size[i] = 0; p_start[i] = 0; p_res[i] = 0; p_live[i] = 0;
    end
    last_pid = 0;
    req.valid = 1'b0;
    req.operation = OP_ALLOC;
    req.request_bytes = '0;
    req.process_id = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();   // sender holds off until all responses are in
    test_random(560);
    test_table_full();
    wait_drained();
    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
